/* sv/spbd_pkg.sv */
// ----------------------------------------------------------------------------
// spbd_pkg
// widths, register indexes, reset values and decision codes shared by the
// spectral peak band detector and its stream interfaces
// ----------------------------------------------------------------------------
package spbd_pkg;

  // payload widths
  localparam int SAMPLE_W   = 16;
  localparam int MAG_W      = 15;
  localparam int PEAK_BIN_W = 10;
  localparam int HITS_W     = 3;
  localparam int CALL_W     = 3;
  localparam int PHASE_W    = 3;

  // configuration widths
  localparam int BAND_LOW_W  = 10;
  localparam int BAND_HIGH_W = 11;
  localparam int HIT_THR_W   = 8;
  localparam int MISS_THR_W  = 7;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 11;

  // frame and hit counters
  localparam int CNT_W = 8;
  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  // parameter defaults
  localparam int FRAME_BINS_MAX_DEF = 1024;
  localparam int MIN_PEAK_BIN_DEF   = 10;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_BAND_A_LOW  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BAND_A_HIGH = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BAND_B_LOW  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BAND_B_HIGH = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_BAND_C_LOW  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_BAND_C_HIGH = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_HIT_THR     = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_MISS_THR    = 3'd7;

  // register reset values
  localparam logic [BAND_LOW_W-1:0]  BAND_A_LOW_RST  = 10'd300;
  localparam logic [BAND_HIGH_W-1:0] BAND_A_HIGH_RST = 11'd350;
  localparam logic [BAND_LOW_W-1:0]  BAND_B_LOW_RST  = 10'd90;
  localparam logic [BAND_HIGH_W-1:0] BAND_B_HIGH_RST = 11'd110;
  localparam logic [BAND_LOW_W-1:0]  BAND_C_LOW_RST  = 10'd110;
  localparam logic [BAND_HIGH_W-1:0] BAND_C_HIGH_RST = 11'd130;
  localparam logic [HIT_THR_W-1:0]   HIT_THR_RST     = 8'd10;
  localparam logic [MISS_THR_W-1:0]  MISS_THR_RST    = 7'd20;

  // decision phases
  localparam logic [PHASE_W-1:0] PH_IDLE   = 3'd0;
  localparam logic [PHASE_W-1:0] PH_COUNT  = 3'd1;
  localparam logic [PHASE_W-1:0] PH_CONF_A = 3'd2;
  localparam logic [PHASE_W-1:0] PH_CONF_C = 3'd3;
  localparam logic [PHASE_W-1:0] PH_CONF_B = 3'd4;
  localparam logic [PHASE_W-1:0] PH_HOLD   = 3'd5;

  // call codes
  localparam logic [CALL_W-1:0] CALL_NONE = 3'h0;
  localparam logic [CALL_W-1:0] CALL_A    = 3'h1;
  localparam logic [CALL_W-1:0] CALL_B    = 3'h2;
  localparam logic [CALL_W-1:0] CALL_C    = 3'h4;

  // band hit bit positions
  localparam int HIT_A = 0;
  localparam int HIT_B = 1;
  localparam int HIT_C = 2;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    sat_inc = (v == CNT_MAX) ? CNT_MAX : v + 1'b1;
  endfunction

endpackage

/* sv/spbd_stream_if.sv */
// ----------------------------------------------------------------------------
// spbd stream interfaces
// valid/ready channels for spectrum bin beats and per-frame result beats
// ----------------------------------------------------------------------------
interface spbd_in_if import spbd_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample;
  logic                       last_bin;

  modport source (output valid, output sample, output last_bin, input ready);
  modport sink   (input valid, input sample, input last_bin, output ready);
endinterface

interface spbd_out_if import spbd_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [PEAK_BIN_W-1:0] peak_bin;
  logic [MAG_W-1:0]      peak_magnitude;
  logic [HITS_W-1:0]     band_hits;
  logic [CALL_W-1:0]     call_code;
  logic [PHASE_W-1:0]    phase;

  modport source (output valid, output peak_bin, output peak_magnitude,
                  output band_hits, output call_code, output phase, input ready);
  modport sink   (input valid, input peak_bin, input peak_magnitude,
                  input band_hits, input call_code, input phase, output ready);
endinterface

/* sv/spectral_peak_band_detector_top.sv */
// ----------------------------------------------------------------------------
// spectral_peak_band_detector_top
// The block takes one spectrum bin beat per clock while no last bin waits, and
// returns one result beat per frame. Each bin is held in an input register,
// and a single registered pass computes its saturated magnitude, updates the
// frame peak and, on the last bin, runs the band test and the decision phase
// step into the result register. A bin that is not the last one always moves
// on; the last bin waits in the input register only while the previous result
// beat is still held in the result register.
// ----------------------------------------------------------------------------
module spectral_peak_band_detector_top import spbd_pkg::*; #(
  parameter int FRAME_BINS_MAX = FRAME_BINS_MAX_DEF,
  parameter int MIN_PEAK_BIN   = MIN_PEAK_BIN_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  spbd_in_if.sink               in_ch,
  spbd_out_if.source            out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int BIN_W = $clog2(FRAME_BINS_MAX);
  localparam int CMP_W = (BIN_W > BAND_HIGH_W) ? BIN_W : BAND_HIGH_W;
  localparam logic [BIN_W-1:0] BIN_LAST = BIN_W'(FRAME_BINS_MAX - 1);
  localparam logic [BIN_W-1:0] BIN_FIRST_BEST = BIN_W'(1);

  // configuration registers
  logic [BAND_LOW_W-1:0]  band_a_low_r, band_b_low_r, band_c_low_r;
  logic [BAND_HIGH_W-1:0] band_a_high_r, band_b_high_r, band_c_high_r;
  logic [HIT_THR_W-1:0]   hit_thr_r;
  logic [MISS_THR_W-1:0]  miss_thr_r;

  // input register
  logic                       s1_vld_r;
  logic signed [SAMPLE_W-1:0] s1_sample_r;
  logic                       s1_last_r;
  logic                       s1_adv;
  logic                       s1_done;

  // frame state
  logic [BIN_W-1:0] bin_idx_r;
  logic [MAG_W-1:0] best_mag_r;
  logic [BIN_W-1:0] best_bin_r;

  // decision state
  logic [PHASE_W-1:0] phase_r, phase_nxt;
  logic [CNT_W-1:0]   cnt_a_r, cnt_a_nxt;
  logic [CNT_W-1:0]   cnt_b_r, cnt_b_nxt;
  logic [CNT_W-1:0]   cnt_c_r, cnt_c_nxt;
  logic [CNT_W-1:0]   miss_cnt_r, miss_cnt_nxt;
  logic [CALL_W-1:0]  call_nxt;

  // result register
  logic                  out_vld_r;
  logic [PEAK_BIN_W-1:0] out_peak_bin_r;
  logic [MAG_W-1:0]      out_peak_mag_r;
  logic [HITS_W-1:0]     out_hits_r;
  logic [CALL_W-1:0]     out_call_r;
  logic [PHASE_W-1:0]    out_phase_r;

  // per-bin datapath
  logic [SAMPLE_W-1:0] abs_val;
  logic [MAG_W-1:0]    mag;
  logic                upd;
  logic [MAG_W-1:0]    best_mag_cur;
  logic [BIN_W-1:0]    best_bin_cur;
  logic [CMP_W-1:0]    bin_cmp;
  logic                above_min;
  logic [HITS_W-1:0]   hits;

  function automatic logic in_band(input logic [CMP_W-1:0] bin,
                                   input logic [BAND_LOW_W-1:0] lo,
                                   input logic [BAND_HIGH_W-1:0] hi);
    in_band = (bin >= CMP_W'(lo)) && (bin < CMP_W'(hi));
  endfunction

  // handshake
  assign s1_adv      = s1_vld_r && (!s1_last_r || !out_vld_r || out_ch.ready);
  assign s1_done     = s1_adv && s1_last_r;
  assign in_ch.ready = !s1_vld_r || s1_adv;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      band_a_low_r  <= BAND_A_LOW_RST;
      band_a_high_r <= BAND_A_HIGH_RST;
      band_b_low_r  <= BAND_B_LOW_RST;
      band_b_high_r <= BAND_B_HIGH_RST;
      band_c_low_r  <= BAND_C_LOW_RST;
      band_c_high_r <= BAND_C_HIGH_RST;
      hit_thr_r     <= HIT_THR_RST;
      miss_thr_r    <= MISS_THR_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_BAND_A_LOW:  band_a_low_r  <= cfg_wdata[BAND_LOW_W-1:0];
        CFG_BAND_A_HIGH: band_a_high_r <= cfg_wdata[BAND_HIGH_W-1:0];
        CFG_BAND_B_LOW:  band_b_low_r  <= cfg_wdata[BAND_LOW_W-1:0];
        CFG_BAND_B_HIGH: band_b_high_r <= cfg_wdata[BAND_HIGH_W-1:0];
        CFG_BAND_C_LOW:  band_c_low_r  <= cfg_wdata[BAND_LOW_W-1:0];
        CFG_BAND_C_HIGH: band_c_high_r <= cfg_wdata[BAND_HIGH_W-1:0];
        CFG_HIT_THR:     hit_thr_r     <= cfg_wdata[HIT_THR_W-1:0];
        CFG_MISS_THR:    miss_thr_r    <= cfg_wdata[MISS_THR_W-1:0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_vld_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_sample_r <= in_ch.sample;
      s1_last_r   <= in_ch.last_bin;
    end
  end

  // magnitude and peak update
  always_comb begin
    abs_val      = s1_sample_r[SAMPLE_W-1] ? (~s1_sample_r + 1'b1) : s1_sample_r;
    mag          = abs_val[SAMPLE_W-1] ? {MAG_W{1'b1}} : abs_val[MAG_W-1:0];
    upd          = mag > best_mag_r;
    best_mag_cur = upd ? mag : best_mag_r;
    best_bin_cur = upd ? bin_idx_r : best_bin_r;
    bin_cmp      = CMP_W'(best_bin_cur);
    above_min    = bin_cmp > CMP_W'(MIN_PEAK_BIN);
    hits[HIT_A]  = above_min && in_band(bin_cmp, band_a_low_r, band_a_high_r);
    hits[HIT_B]  = above_min && in_band(bin_cmp, band_b_low_r, band_b_high_r);
    hits[HIT_C]  = above_min && in_band(bin_cmp, band_c_low_r, band_c_high_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bin_idx_r  <= '0;
      best_mag_r <= '0;
      best_bin_r <= BIN_FIRST_BEST;
    end else if (s1_adv) begin
      if (s1_last_r) begin
        bin_idx_r  <= '0;
        best_mag_r <= '0;
        best_bin_r <= BIN_FIRST_BEST;
      end else begin
        best_mag_r <= best_mag_cur;
        best_bin_r <= best_bin_cur;
        if (bin_idx_r != BIN_LAST) begin
          bin_idx_r <= bin_idx_r + 1'b1;
        end
      end
    end
  end

  // decision phase step
  always_comb begin
    phase_nxt    = phase_r;
    cnt_a_nxt    = cnt_a_r;
    cnt_b_nxt    = cnt_b_r;
    cnt_c_nxt    = cnt_c_r;
    miss_cnt_nxt = miss_cnt_r;
    call_nxt     = CALL_NONE;
    case (phase_r)
      PH_COUNT: begin
        if (hits[HIT_A]) cnt_a_nxt = sat_inc(cnt_a_r);
        if (hits[HIT_B]) cnt_b_nxt = sat_inc(cnt_b_r);
        if (hits[HIT_C]) cnt_c_nxt = sat_inc(cnt_c_r);
        if (hits == '0) miss_cnt_nxt = sat_inc(miss_cnt_r);
        if (cnt_a_nxt >= hit_thr_r) phase_nxt = PH_CONF_A;
        if (cnt_b_nxt >= hit_thr_r) phase_nxt = PH_CONF_B;
        if (cnt_c_nxt >= hit_thr_r) phase_nxt = PH_CONF_C;
        if (miss_cnt_nxt >= {1'b0, miss_thr_r}) phase_nxt = PH_IDLE;
      end
      PH_CONF_A: begin
        call_nxt  = CALL_A;
        phase_nxt = PH_HOLD;
      end
      PH_CONF_C: begin
        call_nxt  = CALL_C;
        phase_nxt = PH_HOLD;
      end
      PH_CONF_B: begin
        call_nxt  = CALL_B;
        phase_nxt = PH_HOLD;
      end
      PH_HOLD: begin
        if (hits == '0) miss_cnt_nxt = sat_inc(miss_cnt_r);
        if (miss_cnt_nxt >= {miss_thr_r, 1'b0}) phase_nxt = PH_IDLE;
      end
      default: begin
        cnt_a_nxt    = '0;
        cnt_b_nxt    = '0;
        cnt_c_nxt    = '0;
        miss_cnt_nxt = '0;
        phase_nxt    = (hits != '0) ? PH_COUNT : PH_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_IDLE;
      cnt_a_r    <= '0;
      cnt_b_r    <= '0;
      cnt_c_r    <= '0;
      miss_cnt_r <= '0;
    end else if (s1_done) begin
      phase_r    <= phase_nxt;
      cnt_a_r    <= cnt_a_nxt;
      cnt_b_r    <= cnt_b_nxt;
      cnt_c_r    <= cnt_c_nxt;
      miss_cnt_r <= miss_cnt_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (s1_done) begin
      out_vld_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_done) begin
      out_peak_bin_r <= PEAK_BIN_W'(best_bin_cur);
      out_peak_mag_r <= best_mag_cur;
      out_hits_r     <= hits;
      out_call_r     <= call_nxt;
      out_phase_r    <= phase_nxt;
    end
  end

  assign out_ch.valid          = out_vld_r;
  assign out_ch.peak_bin       = out_peak_bin_r;
  assign out_ch.peak_magnitude = out_peak_mag_r;
  assign out_ch.band_hits      = out_hits_r;
  assign out_ch.call_code      = out_call_r;
  assign out_ch.phase          = out_phase_r;

  // checks
  a_call_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> $onehot0(out_call_r))
    else $error("call code has more than one bit set");

  a_call_then_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_call_r != CALL_NONE) |-> (out_phase_r == PH_HOLD))
    else $error("call beat not followed by hold phase");

  a_frame_restart: assert property (@(posedge clk) disable iff (!rst_n)
    s1_done |=> (bin_idx_r == '0 && best_mag_r == '0 && best_bin_r == BIN_FIRST_BEST))
    else $error("frame state not cleared after last bin");

  a_bin_bound: assert property (@(posedge clk) disable iff (!rst_n)
    bin_idx_r <= BIN_LAST)
    else $error("bin index beyond frame limit");

  a_result_kept: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && !out_ch.ready) |-> !s1_done)
    else $error("result beat overwritten while stalled");

endmodule
